// ----- rtl/esc_pkg.sv -----
`default_nettype none
package esc_pkg;

    localparam int CFG_W     = 56;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_B   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAS_ERR = 3'd6;

    // radix-2 divider: one quotient bit per stage
    localparam int DIV_W = 64;

    // n / 100 == (n * DIV100_MAGIC) >> DIV100_SHIFT for any 32-bit n
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
    localparam int          DIV100_SHIFT = 37;

    // pipeline latency and delay-line depths, in cycles
    localparam int LAT      = 80;
    localparam int PADC_DLY = 8;
    localparam int HADC_DLY = 13;
    localparam int HTS_DLY  = 4;
    localparam int HD_DLY   = 4;
    localparam int TS_DLY   = 74;
    localparam int HUM_DLY  = 59;
    localparam int GAS_DLY  = 10;

    typedef struct packed {
        logic [19:0] temperature_code;
        logic [19:0] pressure_code;
        logic [15:0] humidity_code;
        logic [9:0]  gas_code;
        logic [3:0]  gas_range_index;
        logic        gas_reading_valid;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [31:0]        pressure_pascal;
        logic [16:0]        humidity_milli;
        logic [31:0]        gas_ohms;
    } t_out_item;

    function automatic logic [30:0] gas_k1(input logic [3:0] idx);
        logic [30:0] v;
        case (idx)
            4'd5, 4'd13: v = 31'd2126008810;
            4'd7:        v = 31'd2130303777;
            4'd10:       v = 31'd2143188679;
            4'd11:       v = 31'd2136746228;
            default:     v = 31'd2147483647;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] gas_k2(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:    v = 32'd4096000000;
            4'd1:    v = 32'd2048000000;
            4'd2:    v = 32'd1024000000;
            4'd3:    v = 32'd512000000;
            4'd4:    v = 32'd255744255;
            4'd5:    v = 32'd127110228;
            4'd6:    v = 32'd64000000;
            4'd7:    v = 32'd32258064;
            4'd8:    v = 32'd16016016;
            4'd9:    v = 32'd8000000;
            4'd10:   v = 32'd4000000;
            4'd11:   v = 32'd2000000;
            4'd12:   v = 32'd1000000;
            4'd13:   v = 32'd500000;
            4'd14:   v = 32'd250000;
            default: v = 32'd125000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/esc_udiv.sv -----
`default_nettype none
module esc_udiv (
    input  wire logic                     i_clk,
    input  wire logic [esc_pkg::DIV_W-1:0] i_num,
    input  wire logic [esc_pkg::DIV_W-1:0] i_den,
    output logic      [esc_pkg::DIV_W-1:0] o_quo
);
    import esc_pkg::*;

    // r_nq holds the numerator bits still to come at the top, quotient bits at the bottom
    logic [DIV_W-1:0] r_rem [1:DIV_W-1];
    logic [DIV_W-1:0] r_den [1:DIV_W-1];
    logic [DIV_W-1:0] r_nq  [1:DIV_W];
    logic [DIV_W:0]   w_try [0:DIV_W-1];
    logic             w_ge  [0:DIV_W-1];

    always_comb begin
        w_try[0] = {{DIV_W{1'b0}}, i_num[DIV_W-1]};
        w_ge[0]  = w_try[0] >= {1'b0, i_den};
        for (int k = 1; k < DIV_W; k++) begin
            w_try[k] = {r_rem[k], r_nq[k][DIV_W-1]};
            w_ge[k]  = w_try[k] >= {1'b0, r_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_nq[1]  <= {i_num[DIV_W-2:0], w_ge[0]};
        r_rem[1] <= w_ge[0] ? DIV_W'(w_try[0] - {1'b0, i_den}) : w_try[0][DIV_W-1:0];
        r_den[1] <= i_den;
        for (int k = 1; k < DIV_W; k++) begin
            r_nq[k+1] <= {r_nq[k][DIV_W-2:0], w_ge[k]};
        end
        for (int k = 1; k < DIV_W - 1; k++) begin
            r_rem[k+1] <= w_ge[k] ? DIV_W'(w_try[k] - {1'b0, r_den[k]})
                                  : w_try[k][DIV_W-1:0];
            r_den[k+1] <= r_den[k];
        end
    end

    assign o_quo = r_nq[DIV_W];

endmodule
`default_nettype wire

// ----- rtl/esc_div100.sv -----
`default_nettype none
module esc_div100 (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_num,
    output logic signed [31:0]      o_quo
);
    import esc_pkg::*;

    logic        r_neg1;
    logic        r_neg2;
    logic [31:0] r_mag;
    logic [63:0] r_prod;
    logic [31:0] w_q;

    assign w_q = 32'(r_prod >> DIV100_SHIFT);

    // truncates toward zero: divide the magnitude, then restore the sign
    always_ff @(posedge i_clk) begin
        r_neg1 <= i_num[31];
        r_mag  <= i_num[31] ? 32'(-i_num) : 32'(i_num);
        r_neg2 <= r_neg1;
        r_prod <= 64'(r_mag) * 64'(DIV100_MAGIC);
        o_quo  <= r_neg2 ? $signed(-w_q) : $signed(w_q);
    end

endmodule
`default_nettype wire

// ----- rtl/env_sensor_compensation.sv -----
// Environmental sensor compensation, fully pipelined. One raw reading may be
// started in every cycle (busy is always low) and its compensated result
// appears on o_result with o_done high for one cycle; results come out in
// order and cannot be held off. The latency is set by the pressure path,
// which runs through a 64-stage radix-2 divider; the gas path uses a second
// one. Calibration registers reset to zero and are written through i_cfg_*;
// the user must write them only while no reading is in flight, as the
// block itself does not enforce it.
`default_nettype none
module env_sensor_compensation (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire esc_pkg::t_in_item              i_item,
    output logic                                o_done,
    output esc_pkg::t_out_item                  o_result,
    input  wire logic                           i_cfg_we,
    input  wire logic [esc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [esc_pkg::CFG_W-1:0]      i_cfg_data
);
    import esc_pkg::*;

    // calibration
    logic [39:0] r_tcal;
    logic [55:0] r_pca;
    logic [47:0] r_pcb;
    logic [23:0] r_pcc;
    logic [47:0] r_hca;
    logic [15:0] r_hcb;
    logic [3:0]  r_gse;

    logic [15:0]        w_t1;
    logic signed [15:0] w_t2;
    logic signed [7:0]  w_t3;
    logic signed [31:0] c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9, c_p10;
    logic signed [31:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6, c_h7;

    logic r_vld [1:LAT-1];

    // temperature
    logic signed [17:0] r_ta;
    logic signed [33:0] r_tpb, r_tsq, r_tcp;
    logic signed [22:0] r_tb;
    logic signed [21:0] w_tc1;
    logic signed [31:0] r_tf, r_ts;
    logic [15:0]        r_tcd [0:TS_DLY-1];

    // pressure
    logic [19:0]        r_padc [0:PADC_DLY-1];
    logic signed [31:0] w_pv1, r_pv1, r_pq;
    logic signed [31:0] r_pqq, r_pm5, r_pm2, r_pa6, r_pa3, r_pm5b, r_pm2b;
    logic signed [31:0] w_pv2a, w_pv1b, r_pv2, r_pv1c;
    logic signed [31:0] r_pden, r_pden2, r_pc1, r_pc2;
    logic signed [31:0] w_pnum;
    logic               w_pbig;
    logic [DIV_W-1:0]   r_pnm, r_pdm, w_pquo;
    logic [2:0]         r_pfl [0:DIV_W];
    logic [31:0]        w_pq32, w_psq;
    logic signed [31:0] r_pc, r_pq3sq, r_pm8, r_prr, r_pr, r_pcb2;
    logic signed [31:0] r_pv1x, r_prrr, r_pv2x, r_pcb3;
    logic signed [31:0] r_pv3m, r_pv1s, r_pv2y, r_pcb4;

    // humidity
    logic [15:0]        r_hadc [0:HADC_DLY-1];
    logic signed [31:0] r_hts  [0:HTS_DLY-1];
    logic signed [31:0] r_hp3, r_hp4, r_hp5, r_hp7;
    logic signed [31:0] w_hd1, w_hd4, w_hd5, w_hd7, w_hd55;
    logic signed [31:0] r_hd1 [0:HD_DLY-1];
    logic signed [31:0] r_hd4 [0:HD_DLY-1];
    logic signed [31:0] r_hd7 [0:HD_DLY-1];
    logic signed [31:0] r_hx;
    logic signed [31:0] r_hv1, r_hv2s, r_hv4, r_hv2, r_hv1b, r_hv4b;
    logic signed [31:0] r_hv3, r_hv4c, r_hv5m, r_hv3b, r_hv4d, r_hv6m, r_hv3c, r_hm;
    logic signed [31:0] w_hs, w_hum;
    logic [16:0]        r_hum;
    logic [16:0]        r_humd [0:HUM_DLY-1];

    // gas
    logic [10:0]        w_gcoef;
    logic [41:0]        r_gm;
    logic [9:0]         r_gadc;
    logic [3:0]         r_grng;
    logic               r_gok1, r_gok2, r_gok3;
    logic [25:0]        w_gv1;
    logic [57:0]        r_gv3m;
    logic signed [28:0] r_gv2, r_gden;
    logic signed [63:0] r_gnum, w_gden64;
    logic [DIV_W-1:0]   r_gnm, r_gdm, w_gquo;
    logic [2:0]         r_gfl [0:DIV_W];
    logic [31:0]        w_gq32;
    logic [31:0]        r_gas;
    logic [31:0]        r_gasd [0:GAS_DLY-1];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal <= '0;
            r_pca  <= '0;
            r_pcb  <= '0;
            r_pcc  <= '0;
            r_hca  <= '0;
            r_hcb  <= '0;
            r_gse  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TEMP:    r_tcal <= i_cfg_data[39:0];
                CFG_PRESS_A: r_pca  <= i_cfg_data[55:0];
                CFG_PRESS_B: r_pcb  <= i_cfg_data[47:0];
                CFG_PRESS_C: r_pcc  <= i_cfg_data[23:0];
                CFG_HUM_A:   r_hca  <= i_cfg_data[47:0];
                CFG_HUM_B:   r_hcb  <= i_cfg_data[15:0];
                CFG_GAS_ERR: r_gse  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign w_t1  = r_tcal[15:0];
    assign w_t2  = $signed(r_tcal[31:16]);
    assign w_t3  = $signed(r_tcal[39:32]);
    assign c_p1  = $signed({16'd0, r_pca[15:0]});
    assign c_p2  = 32'($signed(r_pca[31:16]));
    assign c_p3  = 32'($signed(r_pca[39:32]));
    assign c_p4  = 32'($signed(r_pca[55:40]));
    assign c_p5  = 32'($signed(r_pcb[15:0]));
    assign c_p6  = 32'($signed(r_pcb[23:16]));
    assign c_p7  = 32'($signed(r_pcb[31:24]));
    assign c_p8  = 32'($signed(r_pcb[47:32]));
    assign c_p9  = 32'($signed(r_pcc[15:0]));
    assign c_p10 = $signed({24'd0, r_pcc[23:16]});
    assign c_h1  = $signed({20'd0, r_hca[11:0]});
    assign c_h2  = $signed({20'd0, r_hca[23:12]});
    assign c_h3  = 32'($signed(r_hca[31:24]));
    assign c_h4  = 32'($signed(r_hca[39:32]));
    assign c_h5  = 32'($signed(r_hca[47:40]));
    assign c_h6  = $signed({24'd0, r_hcb[7:0]});
    assign c_h7  = 32'($signed(r_hcb[15:8]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            o_done <= 1'b0;
        end else begin
            r_vld[1] <= start;
            for (int k = 2; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            o_done <= r_vld[LAT-1];
        end
    end

    // ---------------- temperature: stages 1..5
    assign w_tc1 = 22'(r_tsq >>> 12);

    always_ff @(posedge i_clk) begin
        r_ta   <= $signed({1'b0, i_item.temperature_code[19:3]}) - $signed({1'b0, w_t1, 1'b0});
        r_tpb  <= r_ta * w_t2;
        r_tsq  <= (r_ta >>> 1) * (r_ta >>> 1);
        r_tb   <= 23'(r_tpb >>> 11);
        r_tcp  <= w_tc1 * $signed({w_t3, 4'b0000});
        r_tf   <= 32'(r_tb) + 32'(r_tcp >>> 14);
        r_ts   <= (r_tf * 32'sd5 + 32'sd128) >>> 8;
        r_tcd[0] <= r_ts[15:0];
        for (int k = 1; k < TS_DLY; k++) begin
            r_tcd[k] <= r_tcd[k-1];
        end
    end

    // ---------------- pressure: stages 5..11, divider, 76..80
    always_comb begin
        w_pv1  = (r_tf >>> 1) - 32'sd64000;
        w_pv2a = (r_pa6 >>> 2) + (r_pm5b <<< 1);
        w_pv1b = (r_pa3 >>> 3) + (r_pm2b >>> 1);
        w_pbig = (r_pc2[31:30] == 2'b01);
        w_pnum = w_pbig ? r_pc2 : (r_pc2 <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r_padc[0] <= i_item.pressure_code;
        for (int k = 1; k < PADC_DLY; k++) begin
            r_padc[k] <= r_padc[k-1];
        end
        r_pv1  <= w_pv1;
        r_pq   <= w_pv1 >>> 2;
        r_pqq  <= r_pq * r_pq;
        r_pm5  <= r_pv1 * c_p5;
        r_pm2  <= c_p2 * r_pv1;
        r_pa6  <= (r_pqq >>> 11) * c_p6;
        r_pa3  <= (r_pqq >>> 13) * (c_p3 <<< 5);
        r_pm5b <= r_pm5;
        r_pm2b <= r_pm2;
        r_pv2  <= (w_pv2a >>> 2) + (c_p4 <<< 16);
        r_pv1c <= w_pv1b >>> 18;
        r_pden <= ((32'sd32768 + r_pv1c) * c_p1) >>> 15;
        r_pc1  <= (32'sd1048576 - $signed({12'd0, r_padc[PADC_DLY-1]})) - (r_pv2 >>> 12);
        r_pc2  <= r_pc1 * 32'sd3125;
        r_pden2 <= r_pden;
        // divider entry: magnitudes, flags {big, negative, zero divisor}
        r_pnm  <= {32'd0, (w_pnum[31] ? 32'(-w_pnum) : 32'(w_pnum))};
        r_pdm  <= {32'd0, (r_pden2[31] ? 32'(-r_pden2) : 32'(r_pden2))};
        r_pfl[0] <= {w_pbig, w_pnum[31] ^ r_pden2[31], r_pden2 == 32'sd0};
        for (int k = 1; k <= DIV_W; k++) begin
            r_pfl[k] <= r_pfl[k-1];
        end
    end

    esc_udiv u_pdiv (
        .i_clk (i_clk),
        .i_num (r_pnm),
        .i_den (r_pdm),
        .o_quo (w_pquo)
    );

    always_comb begin
        w_pq32 = w_pquo[31:0];
        if (r_pfl[DIV_W][0]) begin
            w_psq = '1;
        end else if (r_pfl[DIV_W][1]) begin
            w_psq = -w_pq32;
        end else begin
            w_psq = w_pq32;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc    <= r_pfl[DIV_W][2] ? $signed({w_psq[30:0], 1'b0}) : $signed(w_psq);
        r_pq3sq <= (r_pc >>> 3) * (r_pc >>> 3);
        r_pm8   <= (r_pc >>> 2) * c_p8;
        r_prr   <= (r_pc >>> 8) * (r_pc >>> 8);
        r_pr    <= r_pc >>> 8;
        r_pcb2  <= r_pc;
        r_pv1x  <= c_p9 * (r_pq3sq >>> 13);
        r_prrr  <= r_prr * r_pr;
        r_pv2x  <= r_pm8 >>> 13;
        r_pcb3  <= r_pcb2;
        r_pv3m  <= r_prrr * c_p10;
        r_pv1s  <= r_pv1x >>> 12;
        r_pv2y  <= r_pv2x;
        r_pcb4  <= r_pcb3;
    end

    // ---------------- humidity: stages 6..20
    always_ff @(posedge i_clk) begin
        r_hadc[0] <= i_item.humidity_code;
        for (int k = 1; k < HADC_DLY; k++) begin
            r_hadc[k] <= r_hadc[k-1];
        end
        r_hts[0] <= r_ts;
        for (int k = 1; k < HTS_DLY; k++) begin
            r_hts[k] <= r_hts[k-1];
        end
        r_hp3 <= r_ts * c_h3;
        r_hp4 <= r_ts * c_h4;
        r_hp5 <= r_ts * c_h5;
        r_hp7 <= r_ts * c_h7;
        r_hd1[0] <= w_hd1;
        r_hd4[0] <= w_hd4;
        r_hd7[0] <= w_hd7;
        for (int k = 1; k < HD_DLY; k++) begin
            r_hd1[k] <= r_hd1[k-1];
            r_hd4[k] <= r_hd4[k-1];
            r_hd7[k] <= r_hd7[k-1];
        end
        r_hx <= r_hts[HTS_DLY-1] * w_hd5;
    end

    esc_div100 u_hd1 (.i_clk(i_clk), .i_num(r_hp3), .o_quo(w_hd1));
    esc_div100 u_hd4 (.i_clk(i_clk), .i_num(r_hp4), .o_quo(w_hd4));
    esc_div100 u_hd5 (.i_clk(i_clk), .i_num(r_hp5), .o_quo(w_hd5));
    esc_div100 u_hd7 (.i_clk(i_clk), .i_num(r_hp7), .o_quo(w_hd7));
    esc_div100 u_hd55 (.i_clk(i_clk), .i_num(r_hx >>> 6), .o_quo(w_hd55));

    assign w_hs  = r_hv3 >>> 14;
    assign w_hum = r_hm >>> 12;

    always_ff @(posedge i_clk) begin
        r_hv2s <= r_hd4[HD_DLY-1] + w_hd55 + 32'sd16384;
        r_hv1  <= ($signed({16'd0, r_hadc[HADC_DLY-1]}) - (c_h1 <<< 4))
                  - (r_hd1[HD_DLY-1] >>> 1);
        r_hv4  <= ((c_h6 <<< 7) + r_hd7[HD_DLY-1]) >>> 4;
        r_hv2  <= (c_h2 * r_hv2s) >>> 10;
        r_hv1b <= r_hv1;
        r_hv4b <= r_hv4;
        r_hv3  <= r_hv1b * r_hv2;
        r_hv4c <= r_hv4b;
        r_hv5m <= w_hs * w_hs;
        r_hv3b <= r_hv3;
        r_hv4d <= r_hv4c;
        r_hv6m <= r_hv4d * (r_hv5m >>> 10);
        r_hv3c <= r_hv3b;
        r_hm   <= ((r_hv3c + (r_hv6m >>> 1)) >>> 10) * 32'sd1000;
        if (w_hum < 0) begin
            r_hum <= '0;
        end else if (w_hum > 32'sd100000) begin
            r_hum <= 17'd100000;
        end else begin
            r_hum <= w_hum[16:0];
        end
        r_humd[0] <= r_hum;
        for (int k = 1; k < HUM_DLY; k++) begin
            r_humd[k] <= r_humd[k-1];
        end
    end

    // ---------------- gas: stages 1..4, divider, 69
    assign w_gcoef  = 11'(12'sd1340 + 12'sd5 * 12'($signed(r_gse)));
    assign w_gv1    = r_gm[41:16];
    assign w_gden64 = 64'(r_gden);

    always_ff @(posedge i_clk) begin
        r_gm   <= 42'(w_gcoef) * 42'(gas_k1(i_item.gas_range_index));
        r_gadc <= i_item.gas_code;
        r_grng <= i_item.gas_range_index;
        r_gok1 <= i_item.gas_reading_valid;
        r_gv3m <= 58'(gas_k2(r_grng)) * 58'(w_gv1);
        r_gv2  <= $signed({4'd0, r_gadc, 15'd0}) - 29'sd16777216 + $signed({3'd0, w_gv1});
        r_gok2 <= r_gok1;
        r_gnum <= $signed({15'd0, r_gv3m[57:9]}) + 64'(r_gv2 >>> 1);
        r_gden <= r_gv2;
        r_gok3 <= r_gok2;
        // divider entry: flags {reading valid, negative, zero divisor}
        r_gnm  <= r_gnum[63] ? 64'(-r_gnum) : 64'(r_gnum);
        r_gdm  <= w_gden64[63] ? 64'(-w_gden64) : 64'(w_gden64);
        r_gfl[0] <= {r_gok3, r_gnum[63] ^ r_gden[28], r_gden == 29'sd0};
        for (int k = 1; k <= DIV_W; k++) begin
            r_gfl[k] <= r_gfl[k-1];
        end
    end

    esc_udiv u_gdiv (
        .i_clk (i_clk),
        .i_num (r_gnm),
        .i_den (r_gdm),
        .o_quo (w_gquo)
    );

    assign w_gq32 = w_gquo[31:0];

    always_ff @(posedge i_clk) begin
        if (!r_gfl[DIV_W][2]) begin
            r_gas <= '0;
        end else if (r_gfl[DIV_W][0]) begin
            r_gas <= '1;
        end else if (r_gfl[DIV_W][1]) begin
            r_gas <= -w_gq32;
        end else begin
            r_gas <= w_gq32;
        end
        r_gasd[0] <= r_gas;
        for (int k = 1; k < GAS_DLY; k++) begin
            r_gasd[k] <= r_gasd[k-1];
        end
    end

    // ---------------- output stage
    always_ff @(posedge i_clk) begin
        o_result.temperature_centi <= $signed(r_tcd[TS_DLY-1]);
        o_result.pressure_pascal   <= r_pcb4 + ((r_pv1s + r_pv2y + (r_pv3m >>> 17)
                                      + (c_p7 <<< 7)) >>> 4);
        o_result.humidity_milli    <= r_humd[HUM_DLY-1];
        o_result.gas_ohms          <= r_gasd[GAS_DLY-1];
    end

endmodule
`default_nettype wire
